// File: hdl/preamble_command_frame_parser_assert.svh
// Assertion macros for the frame parser checker.
// Each macro expects clk and rst_n in scope.
`ifndef PREAMBLE_COMMAND_FRAME_PARSER_ASSERT_SVH
`define PREAMBLE_COMMAND_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication.
`define PCFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pcfp_pkg.sv
`default_nettype none

package pcfp_pkg;

    // Preamble is 0x55 0xAA 0x55 0xAA
    localparam logic [7:0] PREAMBLE_A   = 8'h55;
    localparam logic [7:0] PREAMBLE_B   = 8'hAA;
    localparam int unsigned PREAMBLE_LEN = 4;
    localparam int unsigned PRE_IW       = $clog2(PREAMBLE_LEN);

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_HUNT = 4'b0001,
        ST_CMD  = 4'b0010,
        ST_DATA = 4'b0100,
        ST_EMIT = 4'b1000
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic pre_adv;
        logic pre_clr;
        logic cmd_load;
        logic data_wr;
        logic emit_start;
        logic emit_run;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pre_match;
        logic pre_last;
        logic rx_zero;
        logic store_full;
        logic emit_done;
    } dp_status_t;

    // Expected preamble byte at a given position
    function automatic logic [7:0] preamble_byte(input logic [PRE_IW-1:0] pos);
        logic [7:0] b;
        b = pos[0] ? PREAMBLE_B : PREAMBLE_A;
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pcfp_ram.sv
`default_nettype none

module pcfp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/pcfp_ctrl.sv
`default_nettype none

module pcfp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  pcfp_pkg::dp_status_t status,
    output pcfp_pkg::ctrl_cmd_t  cmd
);

    pcfp_pkg::ctrl_state_t state_reg;
    pcfp_pkg::ctrl_state_t state_next;
    logic                  acc;

    // Input is held off only while a frame is being played out
    assign rx_stall = (state_reg == pcfp_pkg::ST_EMIT);
    assign acc      = rx_valid && !rx_stall;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            pcfp_pkg::ST_HUNT:
            begin
                if (acc)
                begin
                    if (!status.pre_match)
                    begin
                        cmd.pre_clr = 1'b1;
                    end
                    else if (status.pre_last)
                    begin
                        cmd.pre_clr = 1'b1;
                        state_next  = pcfp_pkg::ST_CMD;
                    end
                    else
                    begin
                        cmd.pre_adv = 1'b1;
                    end
                end
            end
            pcfp_pkg::ST_CMD:
            begin
                if (acc)
                begin
                    cmd.cmd_load = 1'b1;
                    state_next   = pcfp_pkg::ST_DATA;
                end
            end
            pcfp_pkg::ST_DATA:
            begin
                if (acc)
                begin
                    if (status.store_full)
                    begin
                        // overflow: drop frame, full restart
                        state_next = pcfp_pkg::ST_HUNT;
                    end
                    else
                    begin
                        cmd.data_wr = 1'b1;
                        if (status.rx_zero)
                        begin
                            cmd.emit_start = 1'b1;
                            state_next     = pcfp_pkg::ST_EMIT;
                        end
                    end
                end
            end
            pcfp_pkg::ST_EMIT:
            begin
                cmd.emit_run = 1'b1;
                if (status.emit_done)
                begin
                    state_next = pcfp_pkg::ST_HUNT;
                end
            end
            default:
            begin
                state_next = pcfp_pkg::ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcfp_pkg::ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/pcfp_dp.sv
`default_nettype none

module pcfp_dp #(
    parameter int unsigned MAX_DATA_BYTES = 16,
    localparam int unsigned AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1,
    localparam int unsigned IW = $clog2(MAX_DATA_BYTES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  pcfp_pkg::ctrl_cmd_t  cmd,
    output pcfp_pkg::dp_status_t status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           command_code,
    output logic [7:0]           data_byte,
    output logic [3:0]           data_index,
    output logic                 last
);

    logic [pcfp_pkg::PRE_IW-1:0] pre_idx_reg, pre_idx_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] last_idx_reg, last_idx_next;
    logic [IW-1:0] rd_cnt_reg, rd_cnt_next;
    logic [AW-1:0] ld_idx_reg, ld_idx_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_cmd_reg, out_data_reg;
    logic [3:0]    out_index_reg;
    logic          out_last_reg;
    logic [7:0]    ram_rd_data;
    logic          out_free, load, issue, ld_last;

    // Frame store
    pcfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DATA_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.data_wr),
        .wr_addr (wr_idx_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Status toward the controller
    assign ld_last           = (ld_idx_reg == last_idx_reg);
    assign status.pre_match  = (rx_byte == pcfp_pkg::preamble_byte(pre_idx_reg));
    assign status.pre_last   = (pre_idx_reg == pcfp_pkg::PRE_IW'(pcfp_pkg::PREAMBLE_LEN - 1));
    assign status.rx_zero    = (rx_byte == 8'h00);
    assign status.store_full = (wr_idx_reg == IW'(MAX_DATA_BYTES));
    assign status.emit_done  = load && ld_last;

    // Playout pipeline: read issue, then load into the output register
    assign out_free = !out_valid_reg || !out_stall;
    assign load     = rd_pend_reg && out_free;
    assign issue    = cmd.emit_run && (rd_cnt_reg <= IW'(last_idx_reg))
                      && (!rd_pend_reg || load);

    always_comb
    begin
        pre_idx_next  = pre_idx_reg;
        cmd_next      = cmd_reg;
        wr_idx_next   = wr_idx_reg;
        last_idx_next = last_idx_reg;
        rd_cnt_next   = rd_cnt_reg;
        ld_idx_next   = ld_idx_reg;
        rd_pend_next  = rd_pend_reg;

        if (cmd.pre_clr)
        begin
            pre_idx_next = '0;
        end
        else if (cmd.pre_adv)
        begin
            pre_idx_next = pre_idx_reg + 1'b1;
        end

        if (cmd.cmd_load)
        begin
            cmd_next    = rx_byte;
            wr_idx_next = '0;
        end
        else if (cmd.data_wr)
        begin
            wr_idx_next = wr_idx_reg + 1'b1;
        end

        if (cmd.emit_start)
        begin
            last_idx_next = wr_idx_reg[AW-1:0];
            rd_cnt_next   = '0;
            ld_idx_next   = '0;
        end
        else
        begin
            if (issue)
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
            end
            if (load)
            begin
                ld_idx_next = ld_idx_reg + 1'b1;
            end
        end

        if (issue)
        begin
            rd_pend_next = 1'b1;
        end
        else if (load)
        begin
            rd_pend_next = 1'b0;
        end
    end

    // Output register valid
    assign out_valid_next = load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_idx_reg   <= '0;
            cmd_reg       <= '0;
            wr_idx_reg    <= '0;
            last_idx_reg  <= '0;
            rd_cnt_reg    <= '0;
            ld_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pre_idx_reg   <= pre_idx_next;
            cmd_reg       <= cmd_next;
            wr_idx_reg    <= wr_idx_next;
            last_idx_reg  <= last_idx_next;
            rd_cnt_reg    <= rd_cnt_next;
            ld_idx_reg    <= ld_idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_cmd_reg   <= cmd_reg;
            out_data_reg  <= ram_rd_data;
            out_index_reg <= 4'(ld_idx_reg);
            out_last_reg  <= ld_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command_code = out_cmd_reg;
    assign data_byte    = out_data_reg;
    assign data_index   = out_index_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// File: hdl/preamble_command_frame_parser.sv
// Channel  Dir  Handshake           Payload
// rx       in   rx_valid/rx_stall   rx_byte[7:0]
// out      out  out_valid/out_stall command_code[7:0], data_byte[7:0],
//                                   data_index[3:0], last
//
// Non-terminating bytes are taken at one byte per cycle.
// A zero terminator at data position N starts a playout of N+1 beats,
// one per cycle when out_stall is low, behind a registered store read.
// Playout rate is set by the single read port of the frame store.
// rx_stall is high for the playout; out_stall only delays the playout.
// Async active-low reset returns to preamble hunt; the store is not cleared.
`default_nettype none

module preamble_command_frame_parser #(
    parameter int unsigned MAX_DATA_BYTES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] command_code,
    output logic [7:0] data_byte,
    output logic [3:0] data_index,
    output logic       last
);

    pcfp_pkg::ctrl_cmd_t  cmd;
    pcfp_pkg::dp_status_t status;

    pcfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pcfp_dp #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command_code (command_code),
        .data_byte    (data_byte),
        .data_index   (data_index),
        .last         (last)
    );

endmodule

`default_nettype wire

// File: hdl/pcfp_checker.sv
`default_nettype none

`include "preamble_command_frame_parser_assert.svh"

module pcfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] command_code,
    input logic [7:0] data_byte,
    input logic [3:0] data_index,
    input logic       last
);

    logic        out_wait;
    logic        out_beat;
    logic [20:0] out_payload;

    // Result beat state and its payload
    assign out_wait    = out_valid && out_stall;
    assign out_beat    = out_valid && !out_stall;
    assign out_payload = {command_code, data_byte, data_index, last};

    // Stalled result beat holds
    `PCFP_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_payload), "held beat changed")

    // Mid-frame result means input is held off
    `PCFP_ASSERT_NOW(a_rx_held, out_valid && !last, rx_stall, "input taken during playout")

    // Playout runs without gaps once a non-final beat is taken
    `PCFP_ASSERT_NEXT(a_no_gap, out_beat && !last, out_valid, "gap inside playout")

    // Indexes step by one within a frame
    `PCFP_ASSERT_NEXT(a_idx_step, out_beat && !last, data_index == $past(data_index) + 4'd1, "data index did not advance")

endmodule

bind preamble_command_frame_parser pcfp_checker u_pcfp_checker (.*);

`default_nettype wire
